/* design/crm_pkg.sv */
// ----------------------------------------------------------------------------
// CAN frame route matcher package
// Shared widths, command and result codes, and the queue entry type.
// ----------------------------------------------------------------------------
package crm_pkg;

  localparam int CH_W       = 3;
  localparam int ID_W       = 29;
  localparam int ADDR_W     = CH_W + ID_W;
  localparam int LEN_W      = 7;
  localparam int IDX_W      = 4;
  localparam int KIND_W     = 2;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic OP_ROUTE = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [CMD_W-1:0] CMD_ROUTE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DIAG  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

  localparam logic [KIND_W-1:0] KIND_FORWARD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DIVERT  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NOROUTE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_WRITTEN = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_DIAG_CHANNEL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIAG_ID      = 1'd1;

  localparam logic [CH_W-1:0] DIAG_CHANNEL_RESET = 3'd0;
  localparam logic [ID_W-1:0] DIAG_ID_RESET      = 29'd2016;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [CH_W-1:0]  rx_channel;
    logic [ID_W-1:0]  rx_id;
    logic [LEN_W-1:0] rx_len;
    logic [IDX_W-1:0] entry_index;
    logic             entry_valid;
    logic [CH_W-1:0]  src_channel;
    logic [ID_W-1:0]  src_id;
    logic [CH_W-1:0]  dst_channel;
    logic [ID_W-1:0]  dst_id;
    logic [LEN_W-1:0] max_len;
    logic             to_classic;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t data;
  } q_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] v,
                                               input logic [LEN_W-1:0] max_len);
    return (v > max_len) ? max_len : v;
  endfunction

endpackage

/* design/crm_if.sv */
// ----------------------------------------------------------------------------
// CAN frame route matcher channel interfaces
// Request, result and register write channels with valid/ready transfer.
// ----------------------------------------------------------------------------
interface crm_in_if import crm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             operation;
  logic [CH_W-1:0]  rx_channel;
  logic [ID_W-1:0]  rx_id;
  logic [LEN_W-1:0] rx_length;
  logic [IDX_W-1:0] entry_index;
  logic             entry_valid;
  logic [CH_W-1:0]  entry_src_channel;
  logic [ID_W-1:0]  entry_src_id;
  logic [CH_W-1:0]  entry_dst_channel;
  logic [ID_W-1:0]  entry_dst_id;
  logic [LEN_W-1:0] entry_max_length;
  logic             entry_to_classic;

  modport source (
    output valid, operation, rx_channel, rx_id, rx_length, entry_index, entry_valid,
           entry_src_channel, entry_src_id, entry_dst_channel, entry_dst_id,
           entry_max_length, entry_to_classic,
    input  ready
  );
  modport sink (
    input  valid, operation, rx_channel, rx_id, rx_length, entry_index, entry_valid,
           entry_src_channel, entry_src_id, entry_dst_channel, entry_dst_id,
           entry_max_length, entry_to_classic,
    output ready
  );
endinterface

interface crm_out_if import crm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [IDX_W-1:0]  matched_slot;
  logic [CH_W-1:0]   tx_channel;
  logic [ID_W-1:0]   tx_id;
  logic [LEN_W-1:0]  tx_length;
  logic              tx_is_fd;
  logic              last;

  modport source (
    output valid, kind, matched_slot, tx_channel, tx_id, tx_length, tx_is_fd, last,
    input  ready
  );
  modport sink (
    input  valid, kind, matched_slot, tx_channel, tx_id, tx_length, tx_is_fd, last,
    output ready
  );
endinterface

interface crm_cfg_if import crm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* design/crm_queue.sv */
// ----------------------------------------------------------------------------
// CAN frame route matcher command queue
// Short FIFO of classified commands between the front and back ends.
// ----------------------------------------------------------------------------
module crm_queue import crm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_req_t    push,
  input  logic      pop,
  output cmd_t      head,
  output q_status_t status
);

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push.valid ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push.valid && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push.valid && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.data;
    end
  end

  assign head         = mem_r[rd_ptr_r];
  assign status.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> !status.full)
    else $error("push into full queue");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push.valid) |=> (count_r == $past(count_r) - 1'b1))
    else $error("queue count did not drop on pop");
`endif

endmodule

/* design/crm_front.sv */
// ----------------------------------------------------------------------------
// CAN frame route matcher front end
// Accepts requests, holds the diagnostic registers and classifies each item.
// ----------------------------------------------------------------------------
module crm_front import crm_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  crm_in_if.sink     in_ch,
  crm_cfg_if.sink    cfg_ch,
  input  q_status_t  q_stat,
  output q_req_t     q_push
);

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FRAME_BYTES);

  logic [CH_W-1:0] diag_channel_r, diag_channel_nxt;
  logic [ID_W-1:0] diag_id_r, diag_id_nxt;
  logic            is_diag;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !q_stat.full;

  always_comb begin
    diag_channel_nxt = diag_channel_r;
    diag_id_nxt      = diag_id_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_DIAG_CHANNEL: diag_channel_nxt = cfg_ch.data[CH_W-1:0];
        REG_DIAG_ID:      diag_id_nxt      = cfg_ch.data[ID_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diag_channel_r <= DIAG_CHANNEL_RESET;
      diag_id_r      <= DIAG_ID_RESET;
    end else begin
      diag_channel_r <= diag_channel_nxt;
      diag_id_r      <= diag_id_nxt;
    end
  end

  assign is_diag = (in_ch.rx_channel == diag_channel_r) && (in_ch.rx_id == diag_id_r);

  always_comb begin
    q_push.valid            = in_ch.valid && in_ch.ready;
    q_push.data.rx_channel  = in_ch.rx_channel;
    q_push.data.rx_id       = in_ch.rx_id;
    q_push.data.rx_len      = sat_len(in_ch.rx_length, MAX_LEN);
    q_push.data.entry_index = in_ch.entry_index;
    q_push.data.entry_valid = in_ch.entry_valid;
    q_push.data.src_channel = in_ch.entry_src_channel;
    q_push.data.src_id      = in_ch.entry_src_id;
    q_push.data.dst_channel = in_ch.entry_dst_channel;
    q_push.data.dst_id      = in_ch.entry_dst_id;
    q_push.data.max_len     = sat_len(in_ch.entry_max_length, MAX_LEN);
    q_push.data.to_classic  = in_ch.entry_to_classic;
    if (in_ch.operation == OP_WRITE) begin
      q_push.data.cmd = CMD_WRITE;
    end else if (is_diag) begin
      q_push.data.cmd = CMD_DIAG;
    end else begin
      q_push.data.cmd = CMD_ROUTE;
    end
  end

endmodule

/* design/crm_back.sv */
// ----------------------------------------------------------------------------
// CAN frame route matcher back end
// Owns the route table, executes one command at a time and emits its results.
// ----------------------------------------------------------------------------
module crm_back import crm_pkg::*; #(
  parameter int ROUTE_ENTRIES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      q_head,
  input  q_status_t q_stat,
  output logic      q_pop,
  crm_out_if.source out_ch
);

  localparam int SLOTS  = (ROUTE_ENTRIES < (1 << IDX_W)) ? ROUTE_ENTRIES : (1 << IDX_W);
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EMIT = 1'b1;

  logic                    state_r, state_nxt;
  logic [SLOTS-1:0]        valid_r;
  logic [ADDR_W-1:0]       src_r     [SLOTS];
  logic [ADDR_W-1:0]       dst_r     [SLOTS];
  logic [LEN_W-1:0]        len_r     [SLOTS];
  logic                    classic_r [SLOTS];

  logic [SLOTS-1:0]        match_r, match_nxt, match_calc;
  logic [LEN_W-1:0]        frame_len_r, frame_len_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]       out_kind_r, out_kind_nxt;
  logic [IDX_W-1:0]        out_slot_r, out_slot_nxt;
  logic [CH_W-1:0]         out_chan_r, out_chan_nxt;
  logic [ID_W-1:0]         out_id_r, out_id_nxt;
  logic [LEN_W-1:0]        out_len_r, out_len_nxt;
  logic                    out_fd_r, out_fd_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    out_free;
  logic                    in_range;
  logic                    tbl_write;
  logic [SLOT_W-1:0]       waddr;
  logic [SLOTS-1:0]        pick_oh, rest;
  logic [SLOT_W-1:0]       pick_idx;
  logic [LEN_W-1:0]        pick_len;
  logic [ADDR_W-1:0]       key;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign q_pop     = (state_r == S_IDLE) && !q_stat.empty && out_free;
  assign in_range  = (32'(q_head.entry_index) < ROUTE_ENTRIES);
  assign waddr     = q_head.entry_index[SLOT_W-1:0];
  assign tbl_write = q_pop && (q_head.cmd == CMD_WRITE) && in_range;
  assign key       = {q_head.rx_channel, q_head.rx_id};

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match_calc[i] = valid_r[i] && (src_r[i] == key);
    end
  end

  assign pick_oh = match_r & (~match_r + SLOTS'(1));
  assign rest    = match_r & ~pick_oh;

  always_comb begin
    pick_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (pick_oh[i]) begin
        pick_idx = pick_idx | SLOT_W'(i);
      end
    end
  end

  assign pick_len = (len_r[pick_idx] < frame_len_r) ? len_r[pick_idx] : frame_len_r;

  always_comb begin
    state_nxt     = state_r;
    match_nxt     = match_r;
    frame_len_nxt = frame_len_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_slot_nxt  = out_slot_r;
    out_chan_nxt  = out_chan_r;
    out_id_nxt    = out_id_r;
    out_len_nxt   = out_len_r;
    out_fd_nxt    = out_fd_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          out_slot_nxt = '0;
          out_chan_nxt = '0;
          out_id_nxt   = '0;
          out_len_nxt  = '0;
          out_fd_nxt   = 1'b0;
          out_last_nxt = 1'b1;
          unique case (q_head.cmd)
            CMD_WRITE: begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_WRITTEN;
              out_slot_nxt  = q_head.entry_index;
            end
            CMD_DIAG: begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_DIVERT;
            end
            CMD_ROUTE: begin
              match_nxt     = match_calc;
              frame_len_nxt = q_head.rx_len;
              state_nxt     = S_EMIT;
            end
            default: ;
          endcase
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (match_r == '0) begin
            out_kind_nxt = KIND_NOROUTE;
            out_slot_nxt = '0;
            out_chan_nxt = '0;
            out_id_nxt   = '0;
            out_len_nxt  = '0;
            out_fd_nxt   = 1'b0;
            out_last_nxt = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            out_kind_nxt = KIND_FORWARD;
            out_slot_nxt = IDX_W'(pick_idx);
            out_chan_nxt = dst_r[pick_idx][ADDR_W-1:ID_W];
            out_id_nxt   = dst_r[pick_idx][ID_W-1:0];
            out_len_nxt  = pick_len;
            out_fd_nxt   = !classic_r[pick_idx];
            out_last_nxt = (rest == '0);
            match_nxt    = rest;
            if (rest == '0) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (tbl_write) begin
        valid_r[waddr] <= q_head.entry_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    match_r     <= match_nxt;
    frame_len_r <= frame_len_nxt;
    out_kind_r  <= out_kind_nxt;
    out_slot_r  <= out_slot_nxt;
    out_chan_r  <= out_chan_nxt;
    out_id_r    <= out_id_nxt;
    out_len_r   <= out_len_nxt;
    out_fd_r    <= out_fd_nxt;
    out_last_r  <= out_last_nxt;
    if (tbl_write) begin
      src_r[waddr]     <= {q_head.src_channel, q_head.src_id};
      dst_r[waddr]     <= {q_head.dst_channel, q_head.dst_id};
      len_r[waddr]     <= q_head.max_len;
      classic_r[waddr] <= q_head.to_classic;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_kind_r;
  assign out_ch.matched_slot = out_slot_r;
  assign out_ch.tx_channel   = out_chan_r;
  assign out_ch.tx_id        = out_id_r;
  assign out_ch.tx_length    = out_len_r;
  assign out_ch.tx_is_fd     = out_fd_r;
  assign out_ch.last         = out_last_r;

`ifndef SYNTHESIS
  a_table_write: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_write |=> (valid_r[$past(waddr)] == $past(q_head.entry_valid)))
    else $error("route table valid bit not updated");

  a_no_route: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && match_r == '0 && out_free) |=>
      (out_valid_r && out_kind_r == KIND_NOROUTE && out_last_r && state_r == S_IDLE))
    else $error("missing no-route result");

  a_pending_forward: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_FORWARD && !out_last_r) |->
      (state_r == S_EMIT && match_r != '0))
    else $error("non-final forward result without pending matches");
`endif

endmodule

/* design/can_frame_route_matcher.sv */
// ----------------------------------------------------------------------------
// CAN frame route matcher
// Routes received CAN frame headers through a route table with diagnostic divert.
// ----------------------------------------------------------------------------
// A write or divert result passes the command queue and the output register after the
// request transfer; a routing result passes the queue, the match register and the output
// register. A routed frame gets a parallel table compare, then one result per matching
// entry (up to 16) or one no-route result; the next command waits for the last result.
// Reset clears all route table valid bits and loads diag_channel 0 and diag_id 2016.
module can_frame_route_matcher import crm_pkg::*; #(
  parameter int ROUTE_ENTRIES   = 16,
  parameter int MAX_FRAME_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  crm_in_if.sink     in_ch,
  crm_out_if.source  out_ch,
  crm_cfg_if.sink    cfg_ch
);

  q_req_t    q_push;
  q_status_t q_stat;
  cmd_t      q_head;
  logic      q_pop;

  crm_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_stat (q_stat),
    .q_push (q_push)
  );

  crm_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .pop    (q_pop),
    .head   (q_head),
    .status (q_stat)
  );

  crm_back #(
    .ROUTE_ENTRIES(ROUTE_ENTRIES)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_head (q_head),
    .q_stat (q_stat),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule
